// ===== src/crcfc_pkg.sv =====
package crcfc_pkg;

	localparam logic [7:0]  CRC8_PRESET    = 8'hFF;
	localparam logic [7:0]  CRC8_POLY_REF  = 8'h8C;
	localparam logic [15:0] CRC16_POLY_REF = 16'h8408;
	localparam logic [15:0] SEED_RESET     = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_CHECK   = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	// opcode bit 1 selects CRC-16, bit 0 selects append
	typedef struct packed {
		logic wide;
		logic append;
	} op_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       last;
		op_t        op;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       ok;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0]    count;
		result_t [2:0] res;
	} push_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC8_POLY_REF) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_POLY_REF) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/crcfc_engine.sv =====
module crcfc_engine
	import crcfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  item_t       item,
	input  logic        fire,
	output push_t       push
);

	logic [15:0] seed_q;
	logic [15:0] crc_q;
	logic [7:0]  h0_q;
	logic [7:0]  h1_q;
	logic [1:0]  cnt_q;
	op_t         op_q;
	logic        in_frame_q;

	logic [15:0] crc_e;
	logic [7:0]  h0_e;
	logic [7:0]  h1_e;
	logic [1:0]  cnt_e;
	op_t         op_e;
	logic        in_frame_e;

	logic [15:0] crc_n;
	logic [7:0]  h0_n;
	logic [7:0]  h1_n;
	logic [1:0]  cnt_n;
	logic        in_frame_n;

	logic [7:0]  feed_byte;
	logic [15:0] crc_fed;
	logic        depth_met;
	logic [1:0]  n;
	result_t [2:0] res;

	always_comb begin
		// frame start restarts everything with this byte
		op_e       = item.start ? item.op : op_q;
		crc_e      = item.start ? (item.op.wide ? seed_q : {8'h00, CRC8_PRESET}) : crc_q;
		h0_e       = item.start ? 8'h00 : h0_q;
		h1_e       = item.start ? 8'h00 : h1_q;
		cnt_e      = item.start ? 2'd0 : cnt_q;
		in_frame_e = item.start | in_frame_q;

		feed_byte = op_e.wide ? h0_e : h1_e;
		crc_fed   = op_e.wide ? crc16_update(crc_e, feed_byte)
		                      : {8'h00, crc8_update(crc_e[7:0], feed_byte)};
		depth_met = op_e.wide ? (cnt_e >= 2'd2) : (cnt_e >= 2'd1);

		crc_n      = crc_e;
		h0_n       = h0_e;
		h1_n       = h1_e;
		cnt_n      = cnt_e;
		in_frame_n = in_frame_e;
		n          = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res[i] = '{data: 8'h00, kind: KIND_DATA, ok: 1'b0, last: 1'b0};
		end

		priority if (!in_frame_e) begin
			in_frame_n = 1'b0;
		end else if (!item.last) begin
			if (depth_met) begin
				crc_n = crc_fed;
				if (op_e.append) begin
					res[0] = '{data: feed_byte, kind: KIND_DATA, ok: 1'b0, last: 1'b0};
					n      = 2'd1;
				end
			end
			h0_n  = h1_e;
			h1_n  = item.data;
			cnt_n = (cnt_e == 2'd3) ? cnt_e : cnt_e + 2'd1;
		end else if (cnt_e < 2'd2) begin
			// too short to carry a check field
			in_frame_n = 1'b0;
			if (!op_e.append) begin
				res[0] = '{data: 8'h00, kind: KIND_VERDICT, ok: 1'b0, last: 1'b1};
				n      = 2'd1;
			end else if (cnt_e == 2'd1) begin
				res[0] = '{data: h1_e, kind: KIND_DATA, ok: 1'b0, last: 1'b0};
				res[1] = '{data: item.data, kind: KIND_DATA, ok: 1'b0, last: 1'b1};
				n      = 2'd2;
			end else begin
				res[0] = '{data: item.data, kind: KIND_DATA, ok: 1'b0, last: 1'b1};
				n      = 2'd1;
			end
		end else if (op_e.wide) begin
			in_frame_n = 1'b0;
			crc_n      = crc_fed;
			if (op_e.append) begin
				res[0] = '{data: h0_e, kind: KIND_DATA, ok: 1'b0, last: 1'b0};
				res[1] = '{data: crc_fed[7:0], kind: KIND_CHECK, ok: 1'b0, last: 1'b0};
				res[2] = '{data: crc_fed[15:8], kind: KIND_CHECK, ok: 1'b0, last: 1'b1};
				n      = 2'd3;
			end else begin
				res[0] = '{data: 8'h00, kind: KIND_VERDICT,
				           ok: (crc_fed[7:0] == h1_e) && (crc_fed[15:8] == item.data),
				           last: 1'b1};
				n      = 2'd1;
			end
		end else begin
			in_frame_n = 1'b0;
			crc_n      = crc_fed;
			if (op_e.append) begin
				res[0] = '{data: h1_e, kind: KIND_DATA, ok: 1'b0, last: 1'b0};
				res[1] = '{data: crc_fed[7:0], kind: KIND_CHECK, ok: 1'b0, last: 1'b1};
				n      = 2'd2;
			end else begin
				res[0] = '{data: 8'h00, kind: KIND_VERDICT,
				           ok: (crc_fed[7:0] == item.data), last: 1'b1};
				n      = 2'd1;
			end
		end

		push.count = fire ? n : 2'd0;
		push.res   = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= SEED_RESET;
			crc_q      <= 16'h0000;
			h0_q       <= 8'h00;
			h1_q       <= 8'h00;
			cnt_q      <= 2'd0;
			op_q       <= '0;
			in_frame_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (fire) begin
				crc_q      <= crc_n;
				h0_q       <= h0_n;
				h1_q       <= h1_n;
				cnt_q      <= cnt_n;
				op_q       <= op_e;
				in_frame_q <= in_frame_n;
			end
		end
	end

endmodule

// ===== src/crcfc_out_queue.sv =====
module crcfc_out_queue
	import crcfc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       room,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [2:0] m_tuser,
	output logic       m_tlast
);

	// DEPTH must be a power of two, at least 4, so the pointers wrap on their own; the block does not check it
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	logic [CW-1:0]   count_after_pop;
	result_t         head;

	assign pop             = m_tvalid & m_tready;
	assign count_after_pop = count_q - CW'(pop);
	// a frame end may push three words at once
	assign room            = count_after_pop <= CW'(DEPTH - 3);

	assign head     = mem[rp_q];
	assign m_tvalid = count_q != '0;
	assign m_tdata  = head.data;
	assign m_tuser  = {head.ok, head.kind};
	assign m_tlast  = head.last;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push.count) begin
				mem[wp_q + PW'(i)] <= push.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PW'(push.count);
			rp_q    <= rp_q + PW'(pop);
			count_q <= count_after_pop + CW'(push.count);
		end
	end

endmodule

// ===== src/crc8_crc16_frame_check_append.sv =====
// Path: an accepted word is registered in item_s1, processed by the engine, and pushed into the
// output queue once it has room; its first result word is then presented from the queue.
// Throughput: one input word per cycle; a frame end emits up to three words that drain from the
// queue at one per cycle while m_tready is high, holding off input only when it is nearly full.
// Reset: arst_n clears the CRC state, frame tracking and output queue; the CRC-16 seed
// returns to 0xFFFF.
module crc8_crc16_frame_check_append
	import crcfc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [2:0]  s_tuser,   // frame_start, opcode[1:0]
	input  logic        s_tlast,   // frame_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [2:0]  m_tuser,   // out_kind[1:0], verdict_ok
	output logic        m_tlast    // frame_end
);

	item_t item_s1;
	logic  valid_s1;
	logic  room;
	logic  fire;
	push_t push;

	assign fire     = valid_s1 & room;
	assign s_tready = ~valid_s1 | fire;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{data: s_tdata, start: s_tuser[0], last: s_tlast, op: op_t'(s_tuser[2:1])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	crcfc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_s1),
		.fire      (fire),
		.push      (push)
	);

	crcfc_out_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== src/crcfc_checker.sv =====
module crcfc_checker
	import crcfc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_ok_only_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == KIND_VERDICT)
		else $error("pass flag on a non-verdict word");

	// a verdict closes its frame and carries no byte
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_VERDICT |-> m_tlast && m_tdata == 8'h00)
		else $error("verdict word malformed");

	// a check byte that does not end the frame is followed by the closing check byte
	a_check_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser[1:0] == KIND_CHECK && !m_tlast
			|=> m_tvalid && m_tuser[1:0] == KIND_CHECK && m_tlast)
		else $error("CRC-16 high check byte not next");

endmodule

bind crc8_crc16_frame_check_append crcfc_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
